@@ rtl/dmx_udp_pkg.sv @@
// ----------------------------------------------------------------------------
// dmx_udp_pkg
// Constants shared by the DMX-over-UDP deframer: header offsets, protocol
// identifiers, register indexes and stream widths.
// ----------------------------------------------------------------------------
package dmx_udp_pkg;

    localparam int MAX_SLOTS = 512;

    localparam int OFF_W   = 10;
    localparam int CNT_W   = 10;
    localparam int IDX_W   = 9;
    localparam int UNI_W   = 16;
    localparam int DCNT_W  = 16;

    localparam logic [OFF_W-1:0] OFFSET_MAX = 10'd1023;

    localparam logic [OFF_W-1:0] ART_OPC_LO_OFF  = 10'd8;
    localparam logic [OFF_W-1:0] ART_OPC_HI_OFF  = 10'd9;
    localparam logic [OFF_W-1:0] ART_UNI_LO_OFF  = 10'd14;
    localparam logic [OFF_W-1:0] ART_UNI_HI_OFF  = 10'd15;
    localparam logic [OFF_W-1:0] ART_CNT_HI_OFF  = 10'd16;
    localparam logic [OFF_W-1:0] ART_CNT_LO_OFF  = 10'd17;
    localparam logic [OFF_W-1:0] ART_DATA_START  = 10'd18;

    localparam logic [OFF_W-1:0] ACN_ID_FIRST    = 10'd4;
    localparam logic [OFF_W-1:0] ACN_ID_END      = 10'd16;
    localparam logic [OFF_W-1:0] SACN_UNI_HI_OFF = 10'd113;
    localparam logic [OFF_W-1:0] SACN_UNI_LO_OFF = 10'd114;
    localparam logic [OFF_W-1:0] SACN_CNT_HI_OFF = 10'd123;
    localparam logic [OFF_W-1:0] SACN_CNT_LO_OFF = 10'd124;
    localparam logic [OFF_W-1:0] SACN_START_OFF  = 10'd125;
    localparam logic [OFF_W-1:0] SACN_DATA_START = 10'd126;

    localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;

    localparam logic [7:0] ART_ID [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2d, 8'h4e, 8'h65, 8'h74, 8'h00
    };

    localparam logic [7:0] ACN_ID [12] = '{
        8'h41, 8'h53, 8'h43, 8'h2d, 8'h45, 8'h31,
        8'h2e, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        REG_ARTNET_UNIVERSE = 2'd0,
        REG_SACN_UNIVERSE   = 2'd1,
        REG_RECEIVE_ENABLE  = 2'd2
    } reg_index_t;

    localparam logic SRC_ARTNET = 1'b0;
    localparam logic SRC_SACN   = 1'b1;

    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

endpackage

@@ rtl/dmx_over_udp_deframer.sv @@
// ----------------------------------------------------------------------------
// dmx_over_udp_deframer
// Art-Net ArtDmx / sACN E1.31 receiver: checks headers of UDP payload bytes
// and emits indexed DMX channel values plus a frame-done summary.
// ----------------------------------------------------------------------------
// The result of a payload byte (if any) shows up on the master side in the
// cycle after its transaction. Header checks, field capture and slot
// indexing for a byte are done in a single pass ahead of the output
// register, so throughput is one byte per cycle whenever the downstream side
// keeps m_axis_tready high; a stalled output holds s_axis_tready low. Bytes
// that produce no result (header, ignored or rejected bytes) leave the output
// untouched. Configuration writes are always ready and take effect next cycle.
module dmx_over_udp_deframer
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] payload_byte
    input  logic                              s_axis_tuser,   // [0] packet_source
    input  logic                              s_axis_tlast,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dmx_udp_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [8:0] channel_index,
                                                              // [16:9] channel_value,
                                                              // [26:17] frame_channel_count
    output logic [dmx_udp_pkg::M_TUSER_W-1:0] m_axis_tuser    // [0] channel_valid,
                                                              // [1] frame_done,
                                                              // [2] frame_source
);

    import dmx_udp_pkg::*;

    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(MAX_SLOTS);

    logic [UNI_W-1:0]  artnet_universe_reg;
    logic [UNI_W-1:0]  sacn_universe_reg;
    logic              receive_enable_reg;

    logic [OFF_W-1:0]  byte_offset_reg,      byte_offset_next;
    logic              header_good_reg,      header_good_next;
    logic [DCNT_W-1:0] declared_count_reg,   declared_count_next;
    logic [UNI_W-1:0]  universe_capture_reg, universe_capture_next;
    logic [CNT_W-1:0]  channels_sent_reg,    channels_sent_next;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,  out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg,  out_user_next;

    logic              in_accept;
    logic              src;
    logic [7:0]        b;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  data_start;
    logic [DCNT_W-1:0] sacn_prop;
    logic [3:0]        acn_pos;
    logic              hg;
    logic              emit;
    logic              done;
    logic [CNT_W-1:0]  sent_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign src        = s_axis_tuser;
    assign b          = s_axis_tdata;
    assign off        = byte_offset_reg;
    assign data_start = (src == SRC_SACN) ? SACN_DATA_START : ART_DATA_START;
    assign sacn_prop  = {declared_count_reg[15:8], b};
    assign acn_pos    = off[3:0] - 4'd4;

    always_comb
    begin
        hg                    = header_good_reg && receive_enable_reg;
        declared_count_next   = declared_count_reg;
        universe_capture_next = universe_capture_reg;

        if (src == SRC_ARTNET)
        begin
            if (off < ART_OPC_LO_OFF)
            begin
                if (b != ART_ID[off[2:0]])
                    hg = 1'b0;
            end
            else if (off == ART_OPC_LO_OFF)
            begin
                if (b != ARTDMX_OPCODE[7:0])
                    hg = 1'b0;
            end
            else if (off == ART_OPC_HI_OFF)
            begin
                if (b != ARTDMX_OPCODE[15:8])
                    hg = 1'b0;
            end
            else if (off == ART_UNI_LO_OFF)
            begin
                universe_capture_next = {8'd0, b};
            end
            else if (off == ART_UNI_HI_OFF)
            begin
                universe_capture_next = {b, universe_capture_reg[7:0]};
                if (universe_capture_next != artnet_universe_reg)
                    hg = 1'b0;
            end
            else if (off == ART_CNT_HI_OFF)
            begin
                declared_count_next = {b, 8'd0};
            end
            else if (off == ART_CNT_LO_OFF)
            begin
                declared_count_next = {declared_count_reg[15:8], b};
            end
        end
        else
        begin
            if (off >= ACN_ID_FIRST && off < ACN_ID_END)
            begin
                if (b != ACN_ID[acn_pos])
                    hg = 1'b0;
            end
            else if (off == SACN_UNI_HI_OFF)
            begin
                universe_capture_next = {b, 8'd0};
            end
            else if (off == SACN_UNI_LO_OFF)
            begin
                universe_capture_next = {universe_capture_reg[15:8], b};
                if (universe_capture_next != sacn_universe_reg)
                    hg = 1'b0;
            end
            else if (off == SACN_CNT_HI_OFF)
            begin
                declared_count_next = {b, 8'd0};
            end
            else if (off == SACN_CNT_LO_OFF)
            begin
                declared_count_next = (sacn_prop != '0) ? sacn_prop - 16'd1 : '0;
            end
            else if (off == SACN_START_OFF)
            begin
                if (b != 8'd0)
                    hg = 1'b0;
            end
        end

        // data offsets lie past both count fields, so the registered count is final
        emit = hg && (off >= data_start)
               && ({{(DCNT_W-CNT_W){1'b0}}, channels_sent_reg} < declared_count_reg)
               && (channels_sent_reg < SLOT_LIMIT);

        sent_inc = channels_sent_reg + CNT_W'(emit);
        done     = s_axis_tlast && (sent_inc != '0);

        if (s_axis_tlast)
        begin
            byte_offset_next      = '0;
            header_good_next      = 1'b1;
            declared_count_next   = '0;
            universe_capture_next = '0;
            channels_sent_next    = '0;
        end
        else
        begin
            byte_offset_next   = (off < OFFSET_MAX) ? off + 10'd1 : off;
            header_good_next   = hg;
            channels_sent_next = sent_inc;
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (in_accept && (emit || done))
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0,
                              done ? sent_inc : {CNT_W{1'b0}},
                              emit ? b : 8'd0,
                              emit ? channels_sent_reg[IDX_W-1:0] : {IDX_W{1'b0}}};
            out_user_next  = {done ? src : 1'b0, done, emit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            artnet_universe_reg  <= '0;
            sacn_universe_reg    <= 16'd1;
            receive_enable_reg   <= 1'b0;
            byte_offset_reg      <= '0;
            header_good_reg      <= 1'b1;
            declared_count_reg   <= '0;
            universe_capture_reg <= '0;
            channels_sent_reg    <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ARTNET_UNIVERSE: artnet_universe_reg <= cfg_data;
                    REG_SACN_UNIVERSE:   sacn_universe_reg   <= cfg_data;
                    REG_RECEIVE_ENABLE:  receive_enable_reg  <= cfg_data[0];
                    default:             ;
                endcase
            end
            if (in_accept)
            begin
                byte_offset_reg      <= byte_offset_next;
                header_good_reg      <= header_good_next;
                declared_count_reg   <= declared_count_next;
                universe_capture_reg <= universe_capture_next;
                channels_sent_reg    <= channels_sent_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

`ifndef SYNTHESIS

    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1]))
        else $error("result transaction carries neither a slot nor a frame-done");

    a_sent_capped: assert property (@(posedge clk) disable iff (!rst_n)
        channels_sent_reg <= SLOT_LIMIT)
        else $error("channel count exceeds slot limit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tlast) |=>
            (byte_offset_reg == '0 && channels_sent_reg == '0 && header_good_reg))
        else $error("packet state not cleared after last byte");

    a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[26:17] != '0))
        else $error("frame-done with zero channel count");

    a_sent_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !s_axis_tlast) |=>
            (channels_sent_reg == $past(channels_sent_reg)
             || channels_sent_reg == $past(channels_sent_reg) + 10'd1))
        else $error("channel counter moved by more than one");

`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Art-Net / sACN DMX deframer. Whole UDP payloads
// are streamed in byte by byte, directed first (header errors, short and long
// packets, slot caps, tag switches, offset saturation), then random traffic
// over several register settings. A byte-level predictor computes the
// expected slot and frame-done transactions; a monitor checks each one.
// ----------------------------------------------------------------------------
module tb_top;
    import dmx_udp_pkg::*;

    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_BYTES   = 400;
    localparam int NO_FLIP        = 32'h7fff_ffff;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic             slot_valid;
        logic [IDX_W-1:0] slot_index;
        logic [7:0]       slot_value;
        logic             frame_done;
        logic             frame_src;
        logic [CNT_W-1:0] frame_count;
    } dmx_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index     = '0;
    logic [15:0]          cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // predictor copy of registers and packet state
    logic [UNI_W-1:0]  art_universe_q  = '0;
    logic [UNI_W-1:0]  sacn_universe_q = 16'd1;
    logic              rx_enable_q     = 1'b0;
    logic [OFF_W-1:0]  pkt_offset;
    logic              hdr_ok;
    logic [DCNT_W-1:0] slots_declared;
    logic [UNI_W-1:0]  uni_seen;
    logic [CNT_W-1:0]  slots_sent;

    dmx_result_t expected_results[$];
    int          errors       = 0;
    int          stall_cycles = 0;
    bit          steady       = 1'b0;

    dmx_over_udp_deframer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void restart_packet();
        pkt_offset     = '0;
        hdr_ok         = 1'b1;
        slots_declared = '0;
        uni_seen       = '0;
        slots_sent     = '0;
    endfunction

    function automatic void predict_byte(input logic src, input logic [7:0] b,
                                         input logic last);
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] first_slot;
        logic [15:0]      sacn_prop;
        dmx_result_t      r;
        off        = pkt_offset;
        first_slot = (src == SRC_SACN) ? SACN_DATA_START : ART_DATA_START;
        r          = '0;
        if (!rx_enable_q)
            hdr_ok = 1'b0;
        if (src == SRC_ARTNET)
        begin
            if (off < ART_OPC_LO_OFF)
            begin
                if (b != ART_ID[off[2:0]])
                    hdr_ok = 1'b0;
            end
            else if (off == ART_OPC_LO_OFF)
            begin
                if (b != ARTDMX_OPCODE[7:0])
                    hdr_ok = 1'b0;
            end
            else if (off == ART_OPC_HI_OFF)
            begin
                if (b != ARTDMX_OPCODE[15:8])
                    hdr_ok = 1'b0;
            end
            else if (off == ART_UNI_LO_OFF)
                uni_seen = {8'h00, b};
            else if (off == ART_UNI_HI_OFF)
            begin
                uni_seen = {b, uni_seen[7:0]};
                if (uni_seen != art_universe_q)
                    hdr_ok = 1'b0;
            end
            else if (off == ART_CNT_HI_OFF)
                slots_declared = {b, 8'h00};
            else if (off == ART_CNT_LO_OFF)
                slots_declared = {slots_declared[15:8], b};
        end
        else
        begin
            if (off >= ACN_ID_FIRST && off < ACN_ID_END)
            begin
                if (b != ACN_ID[4'(off - ACN_ID_FIRST)])
                    hdr_ok = 1'b0;
            end
            else if (off == SACN_UNI_HI_OFF)
                uni_seen = {b, 8'h00};
            else if (off == SACN_UNI_LO_OFF)
            begin
                uni_seen = {uni_seen[15:8], b};
                if (uni_seen != sacn_universe_q)
                    hdr_ok = 1'b0;
            end
            else if (off == SACN_CNT_HI_OFF)
                slots_declared = {b, 8'h00};
            else if (off == SACN_CNT_LO_OFF)
            begin
                sacn_prop      = {slots_declared[15:8], b};
                slots_declared = (sacn_prop != 16'd0) ? sacn_prop - 16'd1 : 16'd0;
            end
            else if (off == SACN_START_OFF)
            begin
                if (b != 8'h00)
                    hdr_ok = 1'b0;
            end
        end

        if (hdr_ok && off >= first_slot && slots_sent < slots_declared &&
            slots_sent < MAX_SLOTS)
        begin
            r.slot_valid = 1'b1;
            r.slot_index = slots_sent[IDX_W-1:0];
            r.slot_value = b;
            slots_sent   = slots_sent + 1'b1;
        end

        if (pkt_offset < OFFSET_MAX)
            pkt_offset = pkt_offset + 1'b1;

        if (last)
        begin
            if (slots_sent != 0)
            begin
                r.frame_done  = 1'b1;
                r.frame_src   = src;
                r.frame_count = slots_sent;
            end
            restart_packet();
        end

        if (r.slot_valid || r.frame_done)
            expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // result monitor and watchdog
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        dmx_result_t got;
        dmx_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.slot_index  = m_axis_tdata[8:0];
            got.slot_value  = m_axis_tdata[16:9];
            got.frame_count = m_axis_tdata[26:17];
            got.slot_valid  = m_axis_tuser[0];
            got.frame_done  = m_axis_tuser[1];
            got.frame_src   = m_axis_tuser[2];
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected transaction, expected none, actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("channel_valid", 16'(want.slot_valid), 16'(got.slot_valid));
                check_field("channel_index", 16'(want.slot_index), 16'(got.slot_index));
                check_field("channel_value", 16'(want.slot_value), 16'(got.slot_value));
                check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
                check_field("frame_source", 16'(want.frame_src), 16'(got.frame_src));
                check_field("frame_channel_count", 16'(want.frame_count),
                            16'(got.frame_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL dmx_over_udp_deframer");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic src, input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= src;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(src, b, last);
    endtask

    task automatic send_packet(input byte_q_t p, input logic src, input int flip_at);
        foreach (p[i])
            send_byte((i >= flip_at) ? ~src : src, p[i], i == p.size() - 1);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ARTNET_UNIVERSE: art_universe_q  = value;
            REG_SACN_UNIVERSE:   sacn_universe_q = value;
            REG_RECEIVE_ENABLE:  rx_enable_q     = value[0];
            default: ;
        endcase
    endtask

    function automatic void build_artnet(output byte_q_t p, input logic [15:0] uni,
                                         input logic [15:0] count, input int nslots);
        p = {};
        for (int i = 0; i < 8; i++)
            p.push_back(ART_ID[i]);
        p.push_back(ARTDMX_OPCODE[7:0]);
        p.push_back(ARTDMX_OPCODE[15:8]);
        repeat (4) p.push_back(8'($urandom));
        p.push_back(uni[7:0]);
        p.push_back(uni[15:8]);
        p.push_back(count[15:8]);
        p.push_back(count[7:0]);
        repeat (nslots) p.push_back(8'($urandom));
    endfunction

    function automatic void build_sacn(output byte_q_t p, input logic [15:0] uni,
                                       input logic [15:0] prop_field,
                                       input logic [7:0] start_code, input int nslots);
        p = {};
        repeat (4) p.push_back(8'($urandom));
        for (int i = 0; i < 12; i++)
            p.push_back(ACN_ID[i]);
        while (p.size() < SACN_UNI_HI_OFF)
            p.push_back(8'($urandom));
        p.push_back(uni[15:8]);
        p.push_back(uni[7:0]);
        while (p.size() < SACN_CNT_HI_OFF)
            p.push_back(8'($urandom));
        p.push_back(prop_field[15:8]);
        p.push_back(prop_field[7:0]);
        p.push_back(start_code);
        repeat (nslots) p.push_back(8'($urandom));
    endfunction

    task automatic send_random_packet(output int nbytes);
        byte_q_t     p;
        int          kind;
        int          nslots;
        int          decl;
        int          pos;
        int          flip;
        logic        src;
        kind   = $urandom_range(99);
        nslots = ($urandom_range(19) == 0) ? $urandom_range(520) : $urandom_range(24);
        decl   = ($urandom_range(3) == 0) ? $urandom_range(600)
                                          : nslots + $urandom_range(4) - 2;
        if (decl < 0)
            decl = 0;
        src  = (kind < 60) ? SRC_ARTNET : (kind < 85) ? SRC_SACN : 1'($urandom);
        flip = NO_FLIP;
        if (src == SRC_ARTNET)
            build_artnet(p, art_universe_q, 16'(decl), nslots);
        else
            build_sacn(p, sacn_universe_q, 16'(decl + 1), 8'h00, nslots);
        if (kind >= 85)
        begin
            case ($urandom_range(3))
                0:
                begin
                    if (src == SRC_ARTNET)
                        pos = $urandom_range(ART_CNT_LO_OFF);
                    else if ($urandom_range(1))
                        pos = $urandom_range(ACN_ID_FIRST, ACN_ID_END - 1);
                    else
                        pos = $urandom_range(SACN_UNI_HI_OFF, SACN_START_OFF);
                    p[pos] = p[pos] ^ 8'($urandom_range(255, 1));
                end
                1:
                begin
                    pos = $urandom_range(p.size(), 1);
                    while (p.size() > pos)
                        void'(p.pop_back());
                end
                2:
                begin
                    p = {};
                    repeat ($urandom_range(40, 1)) p.push_back(8'($urandom));
                end
                default:
                    flip = $urandom_range(p.size() - 1);
            endcase
        end
        send_packet(p, src, flip);
        nbytes = p.size();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_receive_disabled();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd4, 4);
        send_packet(p, SRC_ARTNET, NO_FLIP);
        write_reg(REG_RECEIVE_ENABLE, 16'd1);
    endtask

    task automatic test_artnet_frames();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd3, 3);
        p[18] = 8'h00;
        p[19] = 8'hff;
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_artnet(p, art_universe_q, 16'd1, 1);
        send_packet(p, SRC_ARTNET, NO_FLIP);
    endtask

    task automatic test_sacn_frames();
        byte_q_t p;
        build_sacn(p, sacn_universe_q, 16'd4, 8'h00, 3);
        p[126] = 8'hff;
        p[127] = 8'h00;
        send_packet(p, SRC_SACN, NO_FLIP);
    endtask

    task automatic test_zero_counts();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd0, 5);
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_sacn(p, sacn_universe_q, 16'd0, 8'h00, 3);
        send_packet(p, SRC_SACN, NO_FLIP);
    endtask

    task automatic test_short_packets();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd4, 0);
        while (p.size() > 10)
            void'(p.pop_back());
        send_packet(p, SRC_ARTNET, NO_FLIP);
        p = {8'h41};
        send_packet(p, SRC_ARTNET, NO_FLIP);
    endtask

    task automatic test_slot_caps();
        byte_q_t p;
        // trailing bytes past the declared count, then fewer bytes than declared
        build_artnet(p, art_universe_q, 16'd5, 12);
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_artnet(p, art_universe_q, 16'd10, 6);
        send_packet(p, SRC_ARTNET, NO_FLIP);
    endtask

    task automatic test_header_errors();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd4, 4);
        p[3] = 8'h20;
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_artnet(p, art_universe_q, 16'd4, 4);
        p[9] = 8'h52;
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_artnet(p, art_universe_q ^ 16'h8001, 16'd4, 4);
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_sacn(p, sacn_universe_q, 16'd5, 8'hdd, 4);
        send_packet(p, SRC_SACN, NO_FLIP);
    endtask

    task automatic test_source_switch();
        byte_q_t p;
        build_artnet(p, art_universe_q, 16'd40, 40);
        send_packet(p, SRC_ARTNET, 20);
    endtask

    task automatic test_offset_saturation();
        byte_q_t p;
        byte_q_t tail;
        // slots run past the 512 cap; a second header past the saturated
        // offset must not restart parsing
        build_artnet(p, art_universe_q, 16'hffff, 5);
        while (p.size() < 1024)
            p.push_back(8'($urandom));
        build_artnet(tail, art_universe_q, 16'd10, 10);
        foreach (tail[i])
            p.push_back(tail[i]);
        steady = 1'b1;
        send_packet(p, SRC_ARTNET, NO_FLIP);
        steady = 1'b0;
    endtask

    task automatic test_universe_extremes();
        byte_q_t p;
        write_reg(REG_ARTNET_UNIVERSE, 16'hffff);
        write_reg(REG_SACN_UNIVERSE, 16'hffff);
        build_artnet(p, 16'hffff, 16'd2, 2);
        send_packet(p, SRC_ARTNET, NO_FLIP);
        build_sacn(p, 16'hffff, 16'd3, 8'h00, 2);
        send_packet(p, SRC_SACN, NO_FLIP);
        build_artnet(p, 16'h0000, 16'd2, 2);
        send_packet(p, SRC_ARTNET, NO_FLIP);
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_ARTNET_UNIVERSE, (phase == 1) ? 16'h0000 : 16'($urandom));
            write_reg(REG_SACN_UNIVERSE, (phase == 4) ? 16'hffff : 16'($urandom));
            if (phase == 3)
            begin
                write_reg(REG_RECEIVE_ENABLE, 16'd0);
                repeat (3) send_random_packet(n);
                write_reg(REG_RECEIVE_ENABLE, 16'd1);
            end
            steady = (phase == 2);
            while (sent < (phase + 1) * RANDOM_BYTES / 5)
            begin
                send_random_packet(n);
                sent += n;
                if ($urandom_range(15) == 0)
                    drain_results();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        restart_packet();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_receive_disabled();
        test_artnet_frames();
        test_sacn_frames();
        test_zero_counts();
        test_short_packets();
        test_slot_caps();
        test_header_errors();
        test_source_switch();
        test_offset_saturation();
        test_universe_extremes();
        test_random_traffic();
        drain_results();
        if (errors == 0)
            $display("PASS dmx_over_udp_deframer");
        else
            $display("FAIL dmx_over_udp_deframer");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dmx_udp_pkg.sv
rtl/dmx_over_udp_deframer.sv
bench/tb_top.sv
